// ===== design/n8259m_pkg.sv =====
// Shared types, constants and helper functions for the 8259-style bank mapper.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package n8259m_pkg;

	// Cartridge size limits. The configured maximums are capped to these before clamping.
	localparam int CHR_PAGES = 512;
	localparam int PRG_BANKS = 256;

	localparam logic [7:0] PRG_CAP   = 8'(PRG_BANKS - 1);
	localparam logic [8:0] CHR1K_CAP = 9'(CHR_PAGES - 1);
	localparam logic [7:0] CHR2K_CAP = 8'(CHR_PAGES / 2 - 1);

	// CPU address decode.
	localparam logic [15:0] WIN_LO   = 16'h4100;
	localparam logic [15:0] WIN_HI   = 16'h7FFF;
	localparam logic [15:0] SEL_MASK = 16'h0101;
	localparam logic [15:0] SEL_CMD  = 16'h0100;
	localparam logic [15:0] SEL_DATA = 16'h0101;

	// Data register slots with a dedicated meaning.
	localparam logic [2:0] SLOT_PRG    = 3'd5;
	localparam logic [2:0] SLOT_MIRROR = 3'd7;

	// Configuration register indexes.
	localparam logic [2:0] CFG_VARIANT    = 3'd0;
	localparam logic [2:0] CFG_PRG_SW_EN  = 3'd1;
	localparam logic [2:0] CFG_PRG_MAX    = 3'd2;
	localparam logic [2:0] CFG_CHR_1K_MAX = 3'd3;
	localparam logic [2:0] CFG_CHR_2K_MAX = 3'd4;
	localparam logic [2:0] CFG_CHR_IS_RAM = 3'd5;

	localparam logic [1:0] MIRROR_VERTICAL = 2'd0;

	typedef enum logic [1:0] {
		VAR_A = 2'd0,
		VAR_B = 2'd1,
		VAR_C = 2'd2,
		VAR_D = 2'd3
	} variant_t;

	typedef struct packed {
		variant_t   variant;
		logic       prg_switch_enable;
		logic [7:0] prg_bank_max;
		logic [8:0] chr_1k_max;
		logic [7:0] chr_2k_max;
		logic       chr_is_ram;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		variant:           VAR_A,
		prg_switch_enable: 1'b1,
		prg_bank_max:      8'd0,
		chr_1k_max:        9'h1FF,
		chr_2k_max:        8'hFF,
		chr_is_ram:        1'b0
	};

	typedef logic [7:0][7:0] data_arr_t;
	typedef logic [7:0][8:0] page_arr_t;

	typedef struct packed {
		logic [7:0] prg_bank;
		logic [1:0] mirror_mode;
		page_arr_t  chr_page;
	} res_t;

	function automatic logic [7:0] lim8(input logic [7:0] v, input logic [7:0] cap);
		return (v > cap) ? cap : v;
	endfunction

	function automatic logic [8:0] lim9(input logic [8:0] v, input logic [8:0] cap);
		return (v > cap) ? cap : v;
	endfunction

	// A bank number above its maximum is masked with the maximum.
	function automatic logic [7:0] clamp8(input logic [7:0] v, input logic [7:0] max);
		return (v > max) ? (v & max) : v;
	endfunction

	function automatic logic [8:0] clamp9(input logic [8:0] v, input logic [8:0] max);
		return (v > max) ? (v & max) : v;
	endfunction

endpackage

// ===== design/n8259m_chr_calc.sv =====
// CHR page calculation from the data registers for all four board variants.
// Depends on n8259m_pkg.
`timescale 1ns / 1ps

module n8259m_chr_calc (
	input  n8259m_pkg::cfg_t      cfg,
	input  n8259m_pkg::data_arr_t regs,
	input  n8259m_pkg::page_arr_t pages_cur,
	output n8259m_pkg::page_arr_t pages_nxt
);
	import n8259m_pkg::*;

	logic [8:0]      m1;
	logic [7:0]      m2;
	logic [1:0]      sh;
	logic [2:0][1:0] orv;
	logic [2:0]      low;
	logic [7:0]      v8;
	page_arr_t       pages_2k;
	logic [3:0][4:0] pages_d;

	always_comb begin
		m1 = lim9(cfg.chr_1k_max, CHR1K_CAP);
		m2 = lim8(cfg.chr_2k_max, CHR2K_CAP);
		case (cfg.variant)
			VAR_A: begin
				sh  = 2'd1;
				orv = {2'd1, 2'd0, 2'd1};
			end
			VAR_C: begin
				sh  = 2'd2;
				orv = {2'd3, 2'd2, 2'd1};
			end
			default: begin
				sh  = 2'd0;
				orv = '0;
			end
		endcase
	end

	// 2K banking: each pair of 1K pages comes from one 2K bank number.
	always_comb begin
		low      = '0;
		v8       = '0;
		pages_2k = '0;
		for (int k = 0; k < 4; k++) begin
			if (k == 0 || regs[7][0]) begin
				low = regs[0][2:0];
			end else begin
				low = regs[k][2:0];
			end
			v8 = 8'({2'b00, regs[4][2:0], low} << sh);
			if (k > 0) begin
				v8 = v8 | {6'd0, orv[k - 1]};
			end
			v8 = clamp8(v8, m2);
			pages_2k[2 * k]     = {v8, 1'b0};
			pages_2k[2 * k + 1] = {v8, 1'b1};
		end
	end

	// 1K banking: only the lower four pages are programmable.
	always_comb begin
		pages_d[0] = {2'b00, regs[0][2:0]};
		pages_d[1] = {regs[4][0], 1'b0, regs[1][2:0]};
		pages_d[2] = {regs[4][1], 1'b0, regs[2][2:0]};
		pages_d[3] = {regs[4][2], regs[6][0], regs[3][2:0]};
	end

	always_comb begin
		if (cfg.variant == VAR_D) begin
			for (int k = 0; k < 4; k++) begin
				pages_nxt[k]     = clamp9({4'd0, pages_d[k]}, m1);
				pages_nxt[k + 4] = pages_cur[k + 4];
			end
		end else begin
			pages_nxt = pages_2k;
		end
	end

endmodule

// ===== design/n8259m_out_reg.sv =====
// Result register of the bank mapper with its valid/ready handshake.
// Depends on n8259m_pkg.
`timescale 1ns / 1ps

module n8259m_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  n8259m_pkg::res_t   res_in,
	input  logic               ready,
	output logic               valid,
	output n8259m_pkg::res_t   res_out,
	output logic               can_load
);
	import n8259m_pkg::*;

	logic valid_q;
	res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

	// A new result may enter when the register is empty or is being drained.
	assign can_load = !valid_q || ready;
	assign valid    = valid_q;
	assign res_out  = res_q;

endmodule

// ===== design/nes_8259_bank_mapper.sv =====
// Top level of the 8259-style NES cartridge bank mapper.
// Depends on n8259m_pkg, n8259m_chr_calc and n8259m_out_reg.
//
//   Channel  Direction  Handshake                 Payload
//   cfg      in         cfg_write_en              cfg_index, cfg_data
//   in       in         in_valid / in_ready       cpu_address, write_data
//   out      out        out_valid / out_ready     prg_bank, mirror_mode, chr_page_0..7
//
// Every CPU write transfer yields one result, passed through the input register
// and then the result register. A new write is taken every cycle while the result
// is not stalled; the input register and the result register each hold one item,
// and the mapping state is updated as an item leaves the input register. Reset
// clears the registers to their power-on mapping. When out_ready is low the result
// holds, then the input register fills and in_ready drops.
`timescale 1ns / 1ps

module nes_8259_bank_mapper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [2:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] cpu_address,
	input  logic [7:0]  write_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  prg_bank,
	output logic [1:0]  mirror_mode,
	output logic [8:0]  chr_page_0,
	output logic [8:0]  chr_page_1,
	output logic [8:0]  chr_page_2,
	output logic [8:0]  chr_page_3,
	output logic [8:0]  chr_page_4,
	output logic [8:0]  chr_page_5,
	output logic [8:0]  chr_page_6,
	output logic [8:0]  chr_page_7
);
	import n8259m_pkg::*;

	cfg_t        cfg_q;
	logic        valid_s1;
	logic [15:0] addr_s1;
	logic [7:0]  wdata_s1;
	logic [7:0]  command_q;
	data_arr_t   data_q;
	logic [7:0]  prg_q;
	logic [1:0]  mirror_q;
	page_arr_t   chr_q;

	logic        advance;
	logic        out_can_load;
	logic        in_win;
	logic        is_cmd;
	logic        is_data;
	logic [2:0]  slot;
	data_arr_t   data_nxt;
	page_arr_t   chr_calc;
	logic [7:0]  prg_nxt;
	logic [1:0]  mirror_nxt;
	page_arr_t   chr_nxt;
	logic [8:0]  m1;
	res_t        res_d;
	res_t        res_o;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_VARIANT:    cfg_q.variant           <= variant_t'(cfg_data[1:0]);
				CFG_PRG_SW_EN:  cfg_q.prg_switch_enable <= cfg_data[0];
				CFG_PRG_MAX:    cfg_q.prg_bank_max      <= cfg_data[7:0];
				CFG_CHR_1K_MAX: cfg_q.chr_1k_max        <= cfg_data;
				CFG_CHR_2K_MAX: cfg_q.chr_2k_max        <= cfg_data[7:0];
				CFG_CHR_IS_RAM: cfg_q.chr_is_ram        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input register.
	assign advance  = valid_s1 && out_can_load;
	assign in_ready = !valid_s1 || out_can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			addr_s1  <= cpu_address;
			wdata_s1 <= write_data;
		end
	end

	// Decode and next mapping state.
	always_comb begin
		in_win  = (addr_s1 >= WIN_LO) && (addr_s1 <= WIN_HI);
		is_cmd  = in_win && ((addr_s1 & SEL_MASK) == SEL_CMD);
		is_data = in_win && ((addr_s1 & SEL_MASK) == SEL_DATA);
		slot    = command_q[2:0];
		data_nxt = data_q;
		if (is_data) begin
			data_nxt[slot] = wdata_s1;
		end
	end

	n8259m_chr_calc u_chr_calc (
		.cfg       (cfg_q),
		.regs      (data_nxt),
		.pages_cur (chr_q),
		.pages_nxt (chr_calc)
	);

	always_comb begin
		prg_nxt    = prg_q;
		mirror_nxt = mirror_q;
		chr_nxt    = chr_q;
		if (is_data) begin
			if (slot == SLOT_PRG) begin
				if (cfg_q.prg_switch_enable) begin
					prg_nxt = clamp8(wdata_s1, lim8(cfg_q.prg_bank_max, PRG_CAP));
				end
			end else if (slot == SLOT_MIRROR) begin
				mirror_nxt = wdata_s1[0] ? MIRROR_VERTICAL : wdata_s1[2:1];
			end else if (!cfg_q.chr_is_ram) begin
				chr_nxt = chr_calc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_q <= '0;
			data_q    <= '0;
			prg_q     <= '0;
			mirror_q  <= MIRROR_VERTICAL;
			chr_q     <= '0;
		end else if (advance) begin
			if (is_cmd) begin
				command_q <= wdata_s1;
			end
			data_q   <= data_nxt;
			prg_q    <= prg_nxt;
			mirror_q <= mirror_nxt;
			chr_q    <= chr_nxt;
		end
	end

	// In 1K mode the upper pattern table is wired to the last 4K of CHR.
	always_comb begin
		m1                = lim9(cfg_q.chr_1k_max, CHR1K_CAP);
		res_d.prg_bank    = prg_nxt;
		res_d.mirror_mode = mirror_nxt;
		res_d.chr_page    = chr_nxt;
		if (cfg_q.variant == VAR_D && !cfg_q.chr_is_ram) begin
			for (int k = 4; k < 8; k++) begin
				res_d.chr_page[k] = {m1[8:2], 2'(k - 4)};
			end
		end
	end

	n8259m_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.res_in   (res_d),
		.ready    (out_ready),
		.valid    (out_valid),
		.res_out  (res_o),
		.can_load (out_can_load)
	);

	assign prg_bank    = res_o.prg_bank;
	assign mirror_mode = res_o.mirror_mode;
	assign chr_page_0  = res_o.chr_page[0];
	assign chr_page_1  = res_o.chr_page[1];
	assign chr_page_2  = res_o.chr_page[2];
	assign chr_page_3  = res_o.chr_page[3];
	assign chr_page_4  = res_o.chr_page[4];
	assign chr_page_5  = res_o.chr_page[5];
	assign chr_page_6  = res_o.chr_page[6];
	assign chr_page_7  = res_o.chr_page[7];

	// An empty result register must never hold back the input side.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_valid) |-> in_ready)
		else $error("input stalled while result register empty");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("processed write produced no result");

	a_prg_locked: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && is_data && slot == SLOT_PRG && !cfg_q.prg_switch_enable)
		|=> $stable(prg_q))
		else $error("PRG bank changed while switching disabled");

	a_chr_ram_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && cfg_q.chr_is_ram) |=> $stable(chr_q))
		else $error("CHR pages changed while CHR is RAM");

endmodule
